FILE: design/sst_pkg.sv
// Package for the sum segment tree: tree geometry, field widths, opcodes, FSM state type.
// No dependencies.
package sst_pkg;

  localparam int LEAVES  = 1024;
  localparam int LEVELS  = (LEAVES > 1) ? $clog2(LEAVES) : 1;
  localparam int SPAN    = 1 << LEVELS;
  localparam int NODES   = 2 * SPAN;
  localparam int ADDR_W  = LEVELS + 1;
  localparam int BOUND_W = ADDR_W + 1;

  localparam int OP_W    = 3;
  localparam int POS_W   = 10;
  localparam int RANGE_W = 11;
  localparam int VAL_W   = 64;

  localparam logic [OP_W-1:0] OP_SET   = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd1;
  localparam logic [OP_W-1:0] OP_READ  = 3'd2;
  localparam logic [OP_W-1:0] OP_RANGE = 3'd3;
  localparam logic [OP_W-1:0] OP_TOTAL = 3'd4;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF_RD,
    ST_UP_WR,
    ST_UP_SUM,
    ST_QL,
    ST_QLW,
    ST_QR,
    ST_QRW
  } state_t;

endpackage

FILE: design/sum_segment_tree_top.sv
// Sum segment tree top level: FSM walking an implicit binary tree held in one node RAM.
// Depends on sst_pkg and sst_ram.
// Rejected or unused opcodes get a zero result and no tree walk.
// Throughput: one transaction at a time.
// Reset: node RAM swept to zero, one node per cycle, busy high; receiver no stall.
module sum_segment_tree_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [sst_pkg::OP_W-1:0]            in_opcode,
  input  logic [sst_pkg::POS_W-1:0]           in_position,
  input  logic [sst_pkg::RANGE_W-1:0]         in_range_left,
  input  logic [sst_pkg::RANGE_W-1:0]         in_range_right,
  input  logic signed [sst_pkg::VAL_W-1:0]    in_operand_value,
  output logic                                out_valid,
  output logic signed [sst_pkg::VAL_W-1:0]    out_result_value
);
  import sst_pkg::*;

  localparam logic [ADDR_W-1:0]  SPAN_A   = ADDR_W'(SPAN);
  localparam logic [BOUND_W-1:0] SPAN_B   = BOUND_W'(SPAN);
  localparam logic [BOUND_W-1:0] LEAVES_B = BOUND_W'(LEAVES);
  localparam logic [ADDR_W-1:0]  ROOT_A   = ADDR_W'(1);
  localparam logic [ADDR_W-1:0]  LAST_A   = ADDR_W'(NODES - 1);

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [ADDR_W-1:0]   k_r, k_nxt;
  logic [BOUND_W-1:0]  l_r, l_nxt;
  logic [BOUND_W-1:0]  r_r, r_nxt;
  logic [OP_W-1:0]     op_r, op_nxt;
  logic [VAL_W-1:0]    x_r, x_nxt;
  logic [VAL_W-1:0]    cur_r, cur_nxt;
  logic [VAL_W-1:0]    res_r, res_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0]    out_val_r, out_val_nxt;

  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [VAL_W-1:0]    wr_data;
  logic [ADDR_W-1:0]   rd_addr;
  logic [VAL_W-1:0]    rd_data;

  logic                accept;
  logic                pos_ok;
  logic [ADDR_W-1:0]   leaf_a;
  logic [BOUND_W-1:0]  l_in, r_in, r_sat;
  logic                range_ok;
  logic [BOUND_W-1:0]  r_dec;
  logic [VAL_W-1:0]    add_sum;

  assign accept   = start && !busy;
  assign pos_ok   = 32'(in_position) < 32'(LEAVES);
  assign leaf_a   = ADDR_W'(in_position) + SPAN_A;
  assign l_in     = BOUND_W'(in_range_left);
  assign r_in     = BOUND_W'(in_range_right);
  assign r_sat    = (r_in > LEAVES_B) ? LEAVES_B : r_in;
  assign range_ok = l_in < r_sat;
  assign r_dec    = r_r - BOUND_W'(1);
  assign add_sum  = rd_data + x_r;

  sst_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_nodes (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_A) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          priority case (in_opcode)
            OP_SET:   state_nxt = pos_ok ? ST_UP_WR : ST_IDLE;
            OP_ADD:   state_nxt = pos_ok ? ST_LEAF_RD : ST_IDLE;
            OP_READ:  state_nxt = pos_ok ? ST_LEAF_RD : ST_IDLE;
            OP_RANGE: state_nxt = range_ok ? ST_QL : ST_IDLE;
            OP_TOTAL: state_nxt = ST_LEAF_RD;
            default:  state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LEAF_RD: state_nxt = (op_r == OP_ADD) ? ST_UP_WR : ST_IDLE;
      ST_UP_WR:   state_nxt = (k_r == ROOT_A) ? ST_IDLE : ST_UP_SUM;
      ST_UP_SUM:  state_nxt = ST_UP_WR;
      ST_QL: begin
        if (l_r >= r_r)    state_nxt = ST_IDLE;
        else if (l_r[0])   state_nxt = ST_QLW;
        else               state_nxt = ST_QR;
      end
      ST_QLW:     state_nxt = ST_QR;
      ST_QR:      state_nxt = r_r[0] ? ST_QRW : ST_QL;
      ST_QRW:     state_nxt = ST_QL;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    clr_cnt_nxt   = clr_cnt_r;
    k_nxt         = k_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    op_nxt        = op_r;
    x_nxt         = x_r;
    cur_nxt       = cur_r;
    res_nxt       = res_r;
    out_valid_nxt = 1'b0;
    out_val_nxt   = out_val_r;
    wr_en         = 1'b0;
    wr_addr       = k_r;
    wr_data       = cur_r;
    rd_addr       = k_r ^ ROOT_A;
    unique case (state_r)
      ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = '0;
        clr_cnt_nxt = clr_cnt_r + ADDR_W'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          op_nxt = in_opcode;
          x_nxt  = in_operand_value;
          k_nxt  = leaf_a;
          res_nxt = '0;
          rd_addr = leaf_a;
          l_nxt  = l_in + SPAN_B;
          r_nxt  = r_sat + SPAN_B;
          priority case (in_opcode)
            OP_SET: begin
              cur_nxt = in_operand_value;
              res_nxt = in_operand_value;
              if (!pos_ok) begin
                out_valid_nxt = 1'b1;
                out_val_nxt   = '0;
              end
            end
            OP_ADD, OP_READ: begin
              if (!pos_ok) begin
                out_valid_nxt = 1'b1;
                out_val_nxt   = '0;
              end
            end
            OP_RANGE: begin
              if (!range_ok) begin
                out_valid_nxt = 1'b1;
                out_val_nxt   = '0;
              end
            end
            OP_TOTAL: rd_addr = ROOT_A;
            default: begin
              out_valid_nxt = 1'b1;
              out_val_nxt   = '0;
            end
          endcase
        end
      end
      ST_LEAF_RD: begin
        if (op_r == OP_ADD) begin
          cur_nxt = add_sum;
          res_nxt = add_sum;
        end else begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = rd_data;
        end
      end
      ST_UP_WR: begin
        wr_en = 1'b1;
        if (k_r == ROOT_A) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
        end
      end
      ST_UP_SUM: begin
        cur_nxt = cur_r + rd_data;
        k_nxt   = k_r >> 1;
      end
      ST_QL: begin
        rd_addr = l_r[ADDR_W-1:0];
        if (l_r >= r_r) begin
          out_valid_nxt = 1'b1;
          out_val_nxt   = res_r;
        end else if (l_r[0]) begin
          l_nxt = l_r + BOUND_W'(1);
        end
      end
      ST_QLW: res_nxt = res_r + rd_data;
      ST_QR: begin
        rd_addr = r_dec[ADDR_W-1:0];
        if (r_r[0]) begin
          r_nxt = r_dec;
        end else begin
          l_nxt = l_r >> 1;
          r_nxt = r_r >> 1;
        end
      end
      ST_QRW: begin
        res_nxt = res_r + rd_data;
        l_nxt   = l_r >> 1;
        r_nxt   = r_r >> 1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    k_r       <= k_nxt;
    l_r       <= l_nxt;
    r_r       <= r_nxt;
    op_r      <= op_nxt;
    x_r       <= x_nxt;
    cur_r     <= cur_nxt;
    res_r     <= res_nxt;
    out_val_r <= out_val_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_val_r;

  a_no_self_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && state_r != ST_CLEAR) |-> (wr_addr != rd_addr))
    else $error("node write collides with sibling read");

  a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ($past(state_r) != ST_CLEAR))
    else $error("result produced during clearing sweep");

  a_range_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_QLW || state_r == ST_QR || state_r == ST_QRW) |-> (l_r <= r_r))
    else $error("range bounds crossed");

  a_walk_node_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UP_WR || state_r == ST_UP_SUM) |-> (k_r != '0))
    else $error("update walk reached node zero");

endmodule

FILE: design/sst_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module sst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
